@@ sv/bhc_pkg.sv @@
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types, register indexes and commutation tables for the hall sensor
// six-step commutation block.
// ----------------------------------------------------------------------------
package bhc_pkg;

   // sector count and the code used for an invalid or rejected event
   localparam int unsigned SECTORS    = 6;
   localparam logic [2:0]  BAD_SECTOR = 3'd6;

   // compensation constants
   localparam logic [7:0] COMP_MIN_WIDTH = 8'd40;
   localparam logic [7:0] COMP_ADD       = 8'h80;
   localparam logic [7:0] COMP_SAT       = 8'hff;

   // register reset values
   localparam logic [7:0] MIN_INTERVAL_RESET = 8'd40;
   localparam logic [7:0] COMP_THRESH_RESET  = 8'd30;
   localparam logic [7:0] COMP_OFFSET_RESET  = 8'd0;

   // configuration register indexes
   localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
   localparam logic [2:0] REG_COMP_THRESH  = 3'd1;
   localparam logic [2:0] REG_COMP_OFFSET  = 3'd2;
   localparam logic [2:0] REG_COMP_ENABLE  = 3'd3;
   localparam logic [2:0] REG_BRAKE_ENABLE = 3'd4;

   // drive mode codes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_MOTOR = 2'd1;
   localparam logic [1:0] MODE_BRAKE = 2'd2;

   // action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_HALL = 1'b1;

   typedef struct packed {
      logic       action;
      logic [2:0] hall_first;
      logic [2:0] hall_second;
      logic       flag_start;
      logic       flag_on;
      logic       flag_brake;
      logic [7:0] avg_current;
      logic [7:0] pwm_width;
      logic [7:0] current_sample;
   } req_type;

   typedef struct packed {
      logic [2:0] sector;
      logic       hall_error;
      logic [1:0] drive_mode;
      logic [7:0] port_b_value;
      logic [7:0] port_d_value;
      logic [2:0] chan_a_enable;
      logic [2:0] chan_b_enable;
      logic       timer_resync;
      logic       comp_active;
      logic [7:0] comp_width;
      logic [7:0] comp_value;
   } rsp_type;

   // 120-degree hall code to sector, codes 0 and 7 are invalid
   function automatic logic [2:0] code_to_sector(input logic [2:0] code);
      logic [2:0] s;
      case (code)
         3'd5:    s = 3'd0;
         3'd4:    s = 3'd1;
         3'd6:    s = 3'd2;
         3'd2:    s = 3'd3;
         3'd3:    s = 3'd4;
         3'd1:    s = 3'd5;
         default: s = BAD_SECTOR;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] port_b_pattern(input logic [2:0] s);
      logic [7:0] v;
      case (s)
         3'd4, 3'd5: v = 8'hfb;
         default:    v = 8'hff;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] port_d_pattern(input logic [2:0] s);
      logic [7:0] v;
      case (s)
         3'd0, 3'd1: v = 8'hf7;
         3'd2, 3'd3: v = 8'hdf;
         default:    v = 8'hff;
      endcase
      return v;
   endfunction

   // motoring: one phase has both compare outputs enabled
   function automatic logic [2:0] motor_enable(input logic [2:0] s);
      logic [2:0] v;
      case (s)
         3'd1, 3'd2: v = 3'b010;
         3'd3, 3'd4: v = 3'b100;
         default:    v = 3'b001;
      endcase
      return v;
   endfunction

   // braking: low-side compare outputs on two phases
   function automatic logic [2:0] brake_enable_bits(input logic [2:0] s);
      logic [2:0] v;
      case (s)
         3'd0, 3'd1: v = 3'b011;
         3'd2, 3'd3: v = 3'b110;
         default:    v = 3'b101;
      endcase
      return v;
   endfunction

endpackage

@@ sv/bldc_hall_commutation.sv @@
// ----------------------------------------------------------------------------
// bldc_hall_commutation
// Hall sensor six-step commutation: validates hall change events, maps the
// code to a sector and forms the motoring or braking drive pattern.
// ----------------------------------------------------------------------------
// A hall event's result is registered and appears on rsp_ in the cycle after it is taken.
// Throughput: one item per cycle; the output register stalls the input only
// while it holds a result that rsp_stall keeps waiting.
// PWM ticks update the interval counter and give no result.
// Synchronous reset clears the hall history, the counter, the output valid
// and loads the register defaults.
module bldc_hall_commutation (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bhc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bhc_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);

   logic [7:0]  min_interval_ff;
   logic [7:0]  comp_thresh_ff;
   logic [7:0]  comp_offset_ff;
   logic        comp_enable_ff;
   logic        brake_enable_ff;
   logic [2:0]  prev_hall_ff, prev_hall_in;
   logic [15:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bhc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept, load, ok, run_pure, motoring, braking;
   logic [2:0] sector;

   // output register is free when empty or being drained
   assign load      = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !load;
   assign accept    = req_valid && load;

   // event qualification and sector match
   always_comb begin
      run_pure = req_data.flag_on && !req_data.flag_start && !req_data.flag_brake;
      ok = (req_data.hall_first == req_data.hall_second);
      if (ok && run_pure) begin
         if (req_data.hall_second == prev_hall_ff) begin
            ok = 1'b0;
         end else if (count_ff < {8'd0, min_interval_ff}) begin
            ok = 1'b0;
         end
      end
      sector = ok ? bhc_pkg::code_to_sector(req_data.hall_second) : bhc_pkg::BAD_SECTOR;
      motoring = req_data.flag_start && req_data.flag_on && !req_data.flag_brake;
      braking  = !motoring && brake_enable_ff && req_data.flag_brake;
   end

   // result fields
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in.sector     = sector;
      rsp_data_in.hall_error = (sector == bhc_pkg::BAD_SECTOR);
      if (sector != bhc_pkg::BAD_SECTOR) begin
         if (motoring) begin
            rsp_data_in.drive_mode    = bhc_pkg::MODE_MOTOR;
            rsp_data_in.timer_resync  = 1'b1;
            rsp_data_in.port_b_value  = bhc_pkg::port_b_pattern(sector);
            rsp_data_in.port_d_value  = bhc_pkg::port_d_pattern(sector);
            rsp_data_in.chan_a_enable = bhc_pkg::motor_enable(sector);
            rsp_data_in.chan_b_enable = bhc_pkg::motor_enable(sector);
            if (comp_enable_ff && (req_data.avg_current > comp_thresh_ff) &&
                (req_data.pwm_width > bhc_pkg::COMP_MIN_WIDTH)) begin
               rsp_data_in.comp_active = 1'b1;
               rsp_data_in.comp_width  = (req_data.pwm_width < bhc_pkg::COMP_ADD) ?
                                         req_data.pwm_width + bhc_pkg::COMP_ADD :
                                         bhc_pkg::COMP_SAT;
               rsp_data_in.comp_value  = req_data.current_sample - comp_offset_ff;
            end
         end else if (braking) begin
            rsp_data_in.drive_mode    = bhc_pkg::MODE_BRAKE;
            rsp_data_in.port_b_value  = bhc_pkg::port_b_pattern(sector);
            rsp_data_in.port_d_value  = bhc_pkg::port_d_pattern(sector);
            rsp_data_in.chan_b_enable = bhc_pkg::brake_enable_bits(sector);
         end
      end
   end

   // state next values
   always_comb begin
      prev_hall_in = prev_hall_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = accept && (req_data.action == bhc_pkg::ACT_HALL);
      end
      if (accept) begin
         if (req_data.action == bhc_pkg::ACT_TICK) begin
            if (count_ff != 16'hffff) begin
               count_in = count_ff + 16'd1;
            end
         end else begin
            prev_hall_in = req_data.hall_second;
            if (sector != bhc_pkg::BAD_SECTOR) begin
               count_in = '0;
            end
         end
      end
   end

   // control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hall_ff    <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         min_interval_ff <= bhc_pkg::MIN_INTERVAL_RESET;
         comp_thresh_ff  <= bhc_pkg::COMP_THRESH_RESET;
         comp_offset_ff  <= bhc_pkg::COMP_OFFSET_RESET;
         comp_enable_ff  <= 1'b0;
         brake_enable_ff <= 1'b0;
      end else begin
         prev_hall_ff <= prev_hall_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               bhc_pkg::REG_MIN_INTERVAL: min_interval_ff <= csr_data;
               bhc_pkg::REG_COMP_THRESH:  comp_thresh_ff  <= csr_data;
               bhc_pkg::REG_COMP_OFFSET:  comp_offset_ff  <= csr_data;
               bhc_pkg::REG_COMP_ENABLE:  comp_enable_ff  <= csr_data[0];
               bhc_pkg::REG_BRAKE_ENABLE: brake_enable_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sv/bhc_checker.sv @@
// ----------------------------------------------------------------------------
// bhc_checker
// Port-level checks for the hall commutation block, bound to the top level.
// ----------------------------------------------------------------------------
module bhc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bhc_pkg::req_type  req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bhc_pkg::rsp_type  rsp_data
);

   // an accepted hall event shows a result next cycle
   a_event_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == bhc_pkg::ACT_HALL) |=> rsp_valid)
      else $error("hall event gave no result");

   // a tick into an empty output gives no result
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == bhc_pkg::ACT_TICK && !rsp_valid)
      |=> !rsp_valid)
      else $error("tick produced a result");

   // input stalls only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a waiting result");

   // error flag tracks the invalid sector
   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hall_error == (rsp_data.sector == bhc_pkg::BAD_SECTOR)))
      else $error("hall_error does not match sector");

   // no drive change means empty patterns
   a_no_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_mode == bhc_pkg::MODE_NONE) |->
      (rsp_data.port_b_value == 8'd0 && rsp_data.port_d_value == 8'd0 &&
       rsp_data.chan_a_enable == 3'd0 && rsp_data.chan_b_enable == 3'd0 &&
       !rsp_data.comp_active))
      else $error("pattern driven without drive mode");

endmodule

bind bldc_hall_commutation bhc_checker u_bhc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
